// ===== rtl/assert_macros.svh =====
// Assertion macros of the transition counter, used by its top-level RTL file.
// Depends on nothing; a synthesis build defines SYNTHESIS and gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/mtc_pkg.sv =====
// Types and constants of the transition counter.
// Used by the interfaces, controller, datapath and divider.
package mtc_pkg;

    localparam int IN_KEY_W  = 16;
    localparam int STATUS_W  = 3;
    localparam int PROB_W    = 17;
    localparam int FRAC_BITS = 16;
    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << FRAC_BITS;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_BOTH      = 3'd0;
    localparam status_t ST_NEW_ENTRY = 3'd1;
    localparam status_t ST_NEW_ROW   = 3'd2;
    localparam status_t ST_FULL      = 3'd3;
    localparam status_t ST_IGNORED   = 3'd4;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RCHK = 7'b0000010,
        S_RCMP = 7'b0000100,
        S_ECHK = 7'b0001000,
        S_ECMP = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    typedef struct packed {
        logic    load;
        logic    idx_clr;
        logic    idx_inc;
        logic    cap_row;
        logic    wr_new_row;
        logic    wr_hit;
        logic    wr_new_ent;
        logic    div_start;
        logic    set_res;
        status_t res_status;
        logic    res_hit;
        logic    res_use_div;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic has_prev;
        logic idx_at_rows;
        logic row_match;
        logic rows_full;
        logic idx_at_fill;
        logic ent_match;
        logic fill_full;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/mtc_req_if.sv =====
// Request channel of the transition counter: valid/ready plus update or query payload.
// Depends on mtc_pkg.
interface mtc_req_if import mtc_pkg::*;;
    logic                valid;
    logic                ready;
    logic                func;
    logic                has_prev;
    logic [IN_KEY_W-1:0] prev_key;
    logic [IN_KEY_W-1:0] next_key;

    modport source (output valid, func, has_prev, prev_key, next_key, input ready);
    modport sink   (input valid, func, has_prev, prev_key, next_key, output ready);
endinterface

// ===== rtl/mtc_rsp_if.sv =====
// Response channel of the transition counter: valid/ready plus status, hit, probability.
// Depends on mtc_pkg.
interface mtc_rsp_if import mtc_pkg::*;;
    logic              valid;
    logic              ready;
    status_t           status;
    logic              hit;
    logic [PROB_W-1:0] probability;

    modport source (output valid, status, hit, probability, input ready);
    modport sink   (input valid, status, hit, probability, output ready);
endinterface

// ===== rtl/mtc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/mtc_div.sv =====
// Restoring divider: floor(num * 2^16 / den) limited to 2^16 (0 when den is 0), one quotient bit a cycle.
// Depends on mtc_pkg.
module mtc_div import mtc_pkg::*; #(
    parameter int COUNT_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COUNT_BITS-1:0] num,
    input  logic [COUNT_BITS-1:0] den,
    output logic                  done,
    output logic [PROB_W-1:0]     q
);
    localparam int SW = $clog2(FRAC_BITS + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [SW-1:0]         step_reg, step_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [COUNT_BITS-1:0] den_reg, den_next;
    logic [PROB_W-1:0]     q_reg, q_next;
    logic [COUNT_BITS:0]   rem2;
    logic                  ge;

    always_comb
    begin
        rem2      = {rem_reg, 1'b0};
        ge        = rem2 >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (start)
        begin
            den_next = den;
            if (den == '0)
            begin
                q_next    = '0;
                done_next = 1'b1;
            end
            else if (num >= den)
            begin
                q_next    = PROB_ONE;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = num;
                q_next    = '0;
                step_next = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? COUNT_BITS'(rem2 - {1'b0, den_reg}) : COUNT_BITS'(rem2);
            q_next    = {q_reg[PROB_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == SW'(FRAC_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign q    = q_reg;
endmodule

// ===== rtl/mtc_ctrl.sv =====
// Controller state machine: row search, entry search, table writes, division, response.
// Depends on mtc_pkg; drives the datapath through cmd_t and reads sts_t.
module mtc_ctrl import mtc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load    = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_RCHK;
                end
            end
            S_RCHK:
            begin
                if (!sts.is_query && !sts.has_prev)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_IGNORED;
                    state_next     = S_DONE;
                end
                else if (sts.idx_at_rows)
                begin
                    cmd.set_res = 1'b1;
                    if (sts.is_query)
                    begin
                        cmd.res_status = ST_IGNORED;
                    end
                    else if (sts.rows_full)
                    begin
                        cmd.res_status = ST_FULL;
                    end
                    else
                    begin
                        cmd.wr_new_row = 1'b1;
                        cmd.res_status = ST_NEW_ROW;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RCMP;
                end
            end
            S_RCMP:
            begin
                if (sts.row_match)
                begin
                    cmd.cap_row = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_ECHK;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RCHK;
                end
            end
            S_ECHK:
            begin
                if (sts.idx_at_fill)
                begin
                    cmd.set_res = 1'b1;
                    if (sts.is_query)
                    begin
                        cmd.res_status = ST_IGNORED;
                    end
                    else if (sts.fill_full)
                    begin
                        cmd.res_status = ST_FULL;
                    end
                    else
                    begin
                        cmd.wr_new_ent = 1'b1;
                        cmd.res_status = ST_NEW_ENTRY;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ECMP;
                end
            end
            S_ECMP:
            begin
                if (sts.ent_match)
                begin
                    if (sts.is_query)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        cmd.wr_hit     = 1'b1;
                        cmd.set_res    = 1'b1;
                        cmd.res_status = ST_BOTH;
                        state_next     = S_DONE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_ECHK;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.set_res     = 1'b1;
                    cmd.res_status  = ST_IGNORED;
                    cmd.res_hit     = 1'b1;
                    cmd.res_use_div = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
endmodule

// ===== rtl/mtc_dp.sv =====
// Datapath: request registers, row and entry RAMs, search index, divider, response register.
// Depends on mtc_pkg, mtc_ram and mtc_div; steered by cmd_t from the controller.
module mtc_dp import mtc_pkg::*; #(
    parameter int KEY_BITS     = 16,
    parameter int ROWS         = 64,
    parameter int NEXT_PER_ROW = 8,
    parameter int COUNT_BITS   = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                func,
    input  logic                has_prev,
    input  logic [IN_KEY_W-1:0] prev_key,
    input  logic [IN_KEY_W-1:0] next_key,
    input  cmd_t                cmd,
    output sts_t                sts,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output status_t             status,
    output logic                hit,
    output logic [PROB_W-1:0]   probability
);
    localparam int RAW  = $clog2(ROWS);
    localparam int EAW  = $clog2(ROWS * NEXT_PER_ROW);
    localparam int MAXN = (ROWS > NEXT_PER_ROW) ? ROWS : NEXT_PER_ROW;
    localparam int IW   = $clog2(MAXN + 1);
    localparam int FW   = $clog2(NEXT_PER_ROW + 1);
    localparam int RCW  = $clog2(ROWS + 1);
    localparam int RWW  = KEY_BITS + COUNT_BITS + FW;
    localparam int EWW  = KEY_BITS + COUNT_BITS;

    logic                  func_reg, hp_reg;
    logic [KEY_BITS-1:0]   pk_reg, nk_reg;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [RCW-1:0]        row_cnt_reg, row_cnt_next;
    logic [RAW-1:0]        ridx_reg;
    logic [COUNT_BITS-1:0] rtot_reg;
    logic [FW-1:0]         rfill_reg;
    status_t               res_status_reg, out_status_reg;
    logic                  res_hit_reg, out_hit_reg;
    logic [PROB_W-1:0]     res_prob_reg, out_prob_reg;
    logic                  out_valid_reg, out_valid_next;

    logic                  row_we, ent_we;
    logic [RAW-1:0]        row_waddr, ent_row;
    logic [EAW-1:0]        ent_addr, ent_off;
    logic [RWW-1:0]        row_wdata, row_rdata;
    logic [EWW-1:0]        ent_wdata, ent_rdata;
    logic [KEY_BITS-1:0]   rd_key, e_key;
    logic [COUNT_BITS-1:0] rd_tot, e_cnt, tot_inc, cnt_inc;
    logic [FW-1:0]         rd_fill;
    logic                  div_done;
    logic [PROB_W-1:0]     div_q;

    assign rd_key  = row_rdata[RWW-1 -: KEY_BITS];
    assign rd_tot  = row_rdata[FW +: COUNT_BITS];
    assign rd_fill = row_rdata[FW-1:0];
    assign e_key   = ent_rdata[EWW-1 -: KEY_BITS];
    assign e_cnt   = ent_rdata[COUNT_BITS-1:0];
    assign tot_inc = (&rtot_reg) ? rtot_reg : rtot_reg + 1'b1;
    assign cnt_inc = (&e_cnt) ? e_cnt : e_cnt + 1'b1;

    always_comb
    begin
        row_we    = cmd.wr_new_row | cmd.wr_hit | cmd.wr_new_ent;
        ent_we    = row_we;
        row_waddr = cmd.wr_new_row ? idx_reg[RAW-1:0] : ridx_reg;
        ent_row   = cmd.wr_new_row ? idx_reg[RAW-1:0] : ridx_reg;
        ent_off   = cmd.wr_new_row ? '0 : EAW'(idx_reg);
        ent_addr  = EAW'(ent_row) * EAW'(NEXT_PER_ROW) + ent_off;
        if (cmd.wr_new_row)
        begin
            row_wdata = {pk_reg, COUNT_BITS'(1), FW'(1)};
        end
        else
        begin
            row_wdata = {pk_reg, tot_inc, cmd.wr_hit ? rfill_reg : rfill_reg + 1'b1};
        end
        ent_wdata = cmd.wr_hit ? {nk_reg, cnt_inc} : {nk_reg, COUNT_BITS'(1)};
    end

    mtc_ram #(.WIDTH(RWW), .DEPTH(ROWS)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (idx_reg[RAW-1:0]),
        .rdata (row_rdata)
    );

    mtc_ram #(.WIDTH(EWW), .DEPTH(ROWS * NEXT_PER_ROW)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_addr),
        .wdata (ent_wdata),
        .raddr (ent_addr),
        .rdata (ent_rdata)
    );

    mtc_div #(.COUNT_BITS(COUNT_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (e_cnt),
        .den   (rtot_reg),
        .done  (div_done),
        .q     (div_q)
    );

    always_comb
    begin
        sts.is_query    = func_reg;
        sts.has_prev    = hp_reg;
        sts.idx_at_rows = (idx_reg == IW'(row_cnt_reg));
        sts.row_match   = (rd_key == pk_reg);
        sts.rows_full   = (row_cnt_reg == RCW'(ROWS));
        sts.idx_at_fill = (idx_reg == IW'(rfill_reg));
        sts.ent_match   = (e_key == nk_reg);
        sts.fill_full   = (rfill_reg == FW'(NEXT_PER_ROW));
        sts.div_done    = div_done;
        sts.out_free    = !out_valid_reg || rsp_ready;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
        row_cnt_next = cmd.wr_new_row ? row_cnt_reg + 1'b1 : row_cnt_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            row_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            row_cnt_reg   <= row_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            hp_reg   <= has_prev;
            pk_reg   <= KEY_BITS'(prev_key);
            nk_reg   <= KEY_BITS'(next_key);
        end
        if (cmd.cap_row)
        begin
            ridx_reg  <= idx_reg[RAW-1:0];
            rtot_reg  <= rd_tot;
            rfill_reg <= rd_fill;
        end
        else if (cmd.wr_hit || cmd.wr_new_ent)
        begin
            rtot_reg <= tot_inc;
        end
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_status;
            res_hit_reg    <= cmd.res_hit;
            res_prob_reg   <= cmd.res_use_div ? div_q : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_hit_reg    <= res_hit_reg;
            out_prob_reg   <= res_prob_reg;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign hit         = out_hit_reg;
    assign probability = out_prob_reg;
endmodule

// ===== rtl/markov_transition_counter.sv =====
// Path from acceptance to response: each row probed passes S_RCHK and S_RCMP, each entry
// probed S_ECHK and S_ECMP, then S_DONE; a query hit also waits in S_DIV for the divider,
// which yields one quotient bit a cycle.
// One request at a time: the next is accepted only once the FSM is back in S_IDLE, and
// S_DONE waits while the previous response is held.
// Reset: asynchronous active-low; clears row count, search index, FSM and response valid.
`include "assert_macros.svh"
module markov_transition_counter import mtc_pkg::*; #(
    parameter int KEY_BITS     = 16,
    parameter int ROWS         = 64,
    parameter int NEXT_PER_ROW = 8,
    parameter int COUNT_BITS   = 32
) (
    input logic   clk,
    input logic   rst_n,
    mtc_req_if.sink   req,
    mtc_rsp_if.source rsp
);
    cmd_t cmd;
    sts_t sts;

    mtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mtc_dp #(
        .KEY_BITS     (KEY_BITS),
        .ROWS         (ROWS),
        .NEXT_PER_ROW (NEXT_PER_ROW),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .func        (req.func),
        .has_prev    (req.has_prev),
        .prev_key    (req.prev_key),
        .next_key    (req.next_key),
        .cmd         (cmd),
        .sts         (sts),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .status      (rsp.status),
        .hit         (rsp.hit),
        .probability (rsp.probability)
    );

    `ASSERT_NXT(a_one_request, clk, rst_n, req.valid && req.ready, !req.ready)
    `ASSERT_IMP(a_div_on_query, clk, rst_n, cmd.div_start, sts.is_query)
    `ASSERT_IMP(a_row_room, clk, rst_n, cmd.wr_new_row, !sts.rows_full && !sts.is_query)
    `ASSERT_IMP(a_ent_room, clk, rst_n, cmd.wr_new_ent, !sts.fill_full && !sts.is_query)
endmodule

// ===== bench/tb_mtc_bfm_if.sv =====
`timescale 1ns / 1ps
// Request and response records of the bench; the bench reuses the RTL interfaces.
// Depends on mtc_pkg from the RTL.
package tb_mtc_types_pkg;
    import mtc_pkg::*;

    typedef struct {
        logic                func;
        logic                has_prev;
        logic [IN_KEY_W-1:0] prev_key;
        logic [IN_KEY_W-1:0] next_key;
    } mtc_request_t;

    typedef struct {
        status_t           status;
        logic              hit;
        logic [PROB_W-1:0] probability;
    } mtc_outcome_t;
endpackage

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for markov_transition_counter: sends updates and queries through
// mtc_req_if, checks mtc_rsp_if against a transition-table predictor or fixed results.
module tb;
    import mtc_pkg::*;
    import tb_mtc_types_pkg::*;

    localparam int NROWS = 64;
    localparam int NENT  = 8;
    localparam logic FN_UPDATE = 1'b0;
    localparam logic FN_QUERY  = 1'b1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #6 clk = ~clk;

    mtc_req_if req ();
    mtc_rsp_if rsp ();

    markov_transition_counter u_top (.clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source));

    logic [15:0] tbl_row_key [NROWS];
    bit          tbl_row_ok  [NROWS];
    logic [31:0] tbl_total   [NROWS];
    logic [15:0] tbl_ent_key [NROWS*NENT];
    bit          tbl_ent_ok  [NROWS*NENT];
    logic [31:0] tbl_count   [NROWS*NENT];

    mtc_outcome_t expected_q [$];
    int  fail_cnt = 0;
    bit  stim_done = 0;
    bit  hold_go = 0;
    bit  hold_seen = 0;
    int  hold_off = 0;
    int  rx_wait = 0;
    int  fill_level = 4;

    function automatic logic [31:0] sat_bump(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic int lookup_row(logic [15:0] k);
        for (int r = 0; r < NROWS; r++)
            if (tbl_row_ok[r] && tbl_row_key[r] == k)
                return r;
        return -1;
    endfunction

    function automatic int lookup_entry(int r, logic [15:0] k);
        for (int j = 0; j < NENT; j++)
            if (tbl_ent_ok[r*NENT+j] && tbl_ent_key[r*NENT+j] == k)
                return r*NENT + j;
        return -1;
    endfunction

    function automatic mtc_outcome_t learn_transition(mtc_request_t rq);
        mtc_outcome_t o;
        int r;
        int e;
        int j;
        logic [63:0] q;
        o.status = ST_IGNORED;
        o.hit = 1'b0;
        o.probability = '0;
        if (rq.func == FN_QUERY)
        begin
            r = lookup_row(rq.prev_key);
            if (r >= 0)
            begin
                e = lookup_entry(r, rq.next_key);
                if (e >= 0)
                begin
                    o.hit = 1'b1;
                    if (tbl_total[r] != 0)
                    begin
                        q = {16'd0, tbl_count[e], 16'd0} / {32'd0, tbl_total[r]};
                        o.probability = (q > 64'd65536) ? PROB_ONE : q[PROB_W-1:0];
                    end
                end
            end
        end
        else if (rq.has_prev)
        begin
            r = lookup_row(rq.prev_key);
            if (r < 0)
            begin
                for (j = 0; j < NROWS; j++)
                    if (!tbl_row_ok[j])
                        break;
                if (j >= NROWS)
                    o.status = ST_FULL;
                else
                begin
                    tbl_row_ok[j] = 1;
                    tbl_row_key[j] = rq.prev_key;
                    tbl_total[j] = 1;
                    tbl_ent_ok[j*NENT] = 1;
                    tbl_ent_key[j*NENT] = rq.next_key;
                    tbl_count[j*NENT] = 1;
                    o.status = ST_NEW_ROW;
                end
            end
            else
            begin
                e = lookup_entry(r, rq.next_key);
                if (e >= 0)
                begin
                    tbl_total[r] = sat_bump(tbl_total[r]);
                    tbl_count[e] = sat_bump(tbl_count[e]);
                    o.status = ST_BOTH;
                end
                else
                begin
                    for (j = 0; j < NENT; j++)
                        if (!tbl_ent_ok[r*NENT+j])
                            break;
                    if (j >= NENT)
                        o.status = ST_FULL;
                    else
                    begin
                        tbl_total[r] = sat_bump(tbl_total[r]);
                        tbl_ent_ok[r*NENT+j] = 1;
                        tbl_ent_key[r*NENT+j] = rq.next_key;
                        tbl_count[r*NENT+j] = 1;
                        o.status = ST_NEW_ENTRY;
                    end
                end
            end
        end
        return o;
    endfunction

    typedef struct {
        mtc_request_t rq;
        bit           typed;
        mtc_outcome_t res;
    } stim_row_t;

    stim_row_t    directed [$];

    function automatic stim_row_t mk(logic f, logic h, logic [15:0] p, logic [15:0] n,
                                     bit t = 0, status_t s = ST_IGNORED,
                                     logic ht = 0, logic [PROB_W-1:0] pr = 0);
        stim_row_t x;
        x.rq.func = f;
        x.rq.has_prev = h;
        x.rq.prev_key = p;
        x.rq.next_key = n;
        x.typed = t;
        x.res.status = s;
        x.res.hit = ht;
        x.res.probability = pr;
        return x;
    endfunction

    function automatic void add_row(stim_row_t x);
        directed.insert(directed.size(), x);
    endfunction

    task automatic send_request(mtc_request_t rq, bit typed, mtc_outcome_t tr);
        mtc_outcome_t o;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.func <= rq.func;
        req.has_prev <= rq.has_prev;
        req.prev_key <= rq.prev_key;
        req.next_key <= rq.next_key;
        do @(posedge clk); while (!req.ready);
        o = learn_transition(rq);
        expected_q.insert(expected_q.size(), typed ? tr : o);
    endtask

    task automatic release_request();
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_key(int pool);
        return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, pool));
    endfunction

    initial
    begin
        mtc_request_t rq;
        mtc_outcome_t none;
        none = '{default: '0};
        req.valid = 1'b0;
        req.func = 1'b0;
        req.has_prev = 1'b0;
        req.prev_key = '0;
        req.next_key = '0;
        for (int i = 0; i < NROWS; i++) tbl_row_ok[i] = 0;
        for (int i = 0; i < NROWS*NENT; i++) tbl_ent_ok[i] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(mk(FN_QUERY, 1, 16'h0000, 16'h0000, 1, ST_IGNORED, 0, 0));
        add_row(mk(FN_UPDATE, 0, 16'hFFFF, 16'hFFFF, 1, ST_IGNORED, 0, 0));
        add_row(mk(FN_UPDATE, 1, 16'hFFFF, 16'h0000, 1, ST_NEW_ROW, 0, 0));
        add_row(mk(FN_QUERY, 0, 16'hFFFF, 16'h0000, 1, ST_IGNORED, 1, PROB_ONE));
        add_row(mk(FN_UPDATE, 1, 16'hFFFF, 16'h0000, 1, ST_BOTH, 0, 0));
        add_row(mk(FN_UPDATE, 1, 16'hFFFF, 16'hFFFF, 1, ST_NEW_ENTRY, 0, 0));
        add_row(mk(FN_QUERY, 1, 16'hFFFF, 16'hFFFF));
        add_row(mk(FN_QUERY, 1, 16'hFFFF, 16'h0000));
        add_row(mk(FN_QUERY, 1, 16'hFFFF, 16'h1234, 1, ST_IGNORED, 0, 0));
        add_row(mk(FN_UPDATE, 1, 16'h0000, 16'h5555));
        add_row(mk(FN_UPDATE, 1, 16'hAAAA, 16'h5555));
        for (int j = 1; j < NENT; j++)
            add_row(mk(FN_UPDATE, 1, 16'h0000, 16'(16'h0100 + j)));
        add_row(mk(FN_UPDATE, 1, 16'h0000, 16'h7777, 1, ST_FULL, 0, 0));
        add_row(mk(FN_QUERY, 0, 16'h0000, 16'h0101, 1, ST_IGNORED, 1, 16'h2000));
        add_row(mk(FN_QUERY, 1, 16'h0000, 16'h7777, 1, ST_IGNORED, 0, 0));
        foreach (directed[i])
            send_request(directed[i].rq, directed[i].typed, directed[i].res);

        for (int n = 0; n < 550; n++)
        begin
            if (n == 120)
            begin
                hold_go = 1;
            end
            if (n == 250)
            begin
                release_request();
                wait_drained();
            end
            rq.func = ($urandom_range(0, 2) == 0) ? FN_QUERY : FN_UPDATE;
            rq.has_prev = ($urandom_range(0, 9) != 0);
            rq.prev_key = (n < 300) ? pick_key(fill_level) : pick_key(90);
            rq.next_key = pick_key(11);
            if (n == 200) fill_level = 40;
            send_request(rq, 0, none);
        end
        release_request();
        wait_drained();
        repeat (200) @(posedge clk);
        stim_done = 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        int w;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            hold_off <= 0;
            rx_wait <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_go && !hold_seen)
        begin
            hold_seen <= 1'b1;
            hold_off <= 60;
            rsp.ready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            rsp.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (rsp.valid && rsp.ready)
        begin
            w = $urandom_range(0, 11);
            rx_wait <= w;
            rsp.ready <= (w == 0);
        end
        else if (rx_wait > 0)
        begin
            rx_wait <= rx_wait - 1;
            rsp.ready <= (rx_wait == 1);
        end
        else
            rsp.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        mtc_outcome_t exp_o;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected response: status %0d hit %0d prob %0d", $time,
                         rsp.status, rsp.hit, rsp.probability);
                fail_cnt++;
            end
            else
            begin
                exp_o = expected_q.pop_front();
                if (rsp.status !== exp_o.status)
                begin
                    $display("%0t status exp %0d got %0d", $time, exp_o.status, rsp.status);
                    fail_cnt++;
                end
                if (rsp.hit !== exp_o.hit)
                begin
                    $display("%0t hit exp %0d got %0d", $time, exp_o.hit, rsp.hit);
                    fail_cnt++;
                end
                if (rsp.probability !== exp_o.probability)
                begin
                    $display("%0t probability exp %0d got %0d", $time, exp_o.probability,
                             rsp.probability);
                    fail_cnt++;
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        if (expected_q.size() != 0)
        begin
            $display("%0t %0d responses never arrived", $time, expected_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("markov_transition_counter verification clean");
        else
            $display("markov_transition_counter verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("markov_transition_counter verification failed");
        $finish;
    end
endmodule
